FILE: rtl/cvg_pkg.sv
// Shared beat types and constants for the Cauchy variate generator.
`timescale 1ns / 1ps

package cvg_pkg;

    // Number of quotient bits the divider resolves, fixed by the output width.
    localparam int QUO_BITS = 32;

    // Input beat: two uniform fractions.
    typedef struct packed {
        logic [31:0] first_uniform;
        logic [31:0] second_uniform;
    } t_in_beat;

    // Output beat: saturated variate and its clip flag.
    typedef struct packed {
        logic signed [31:0] variate;
        logic               saturated;
    } t_out_beat;

    // Per-item flags that ride along with the division.
    typedef struct packed {
        logic neg;   // ratio is negative
        logic ovf;   // ratio magnitude does not fit in the quotient
    } t_div_flags;

endpackage

FILE: rtl/cvg_front.sv
// Front end: uniform-to-signed mapping, unit disk test and divider setup.
`timescale 1ns / 1ps

module cvg_front
    import cvg_pkg::*;
#(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_in_beat                      i_beat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [SAMPLE_BITS+31:0]       o_rem,
    output logic [SAMPLE_BITS-1:0]        o_b,
    output t_div_flags                    o_flags
);

    localparam int S  = SAMPLE_BITS;
    localparam int RW = SAMPLE_BITS + 32;
    localparam int L  = (SAMPLE_BITS + 1) / 2;
    localparam int H  = SAMPLE_BITS - L;
    localparam int SQ = 2 * SAMPLE_BITS + 1;
    localparam logic [S-1:0]  HALF   = {1'b1, {(S - 1){1'b0}}};
    localparam logic [SQ-1:0] RADIUS = SQ'(1) << (2 * S - 2);

    // Stage valid bits and load enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_ld1, w_ld2, w_ld3, w_ld4;

    assign w_ld4   = !r_v4 || i_ready;
    assign w_ld3   = !r_v3 || w_ld4;
    assign w_ld2   = !r_v2 || w_ld3;
    assign w_ld1   = !r_v1 || w_ld2;
    assign o_ready = w_ld1;
    assign o_valid = r_v4;

    // Stage 1 logic: trim the samples and fold them to magnitude and sign.
    logic [S+31:0] w_ext_u, w_ext_v;
    logic [S-1:0]  w_u, w_v, w_a, w_b;
    logic          w_xneg, w_yneg;

    assign w_ext_u = {{S{1'b0}}, i_beat.first_uniform};
    assign w_ext_v = {{S{1'b0}}, i_beat.second_uniform};
    assign w_u     = w_ext_u[S-1:0];
    assign w_v     = w_ext_v[S-1:0];
    assign w_xneg  = !w_u[S-1];
    assign w_yneg  = !w_v[S-1];
    assign w_a     = w_xneg ? (HALF - w_u) : (w_u - HALF);
    assign w_b     = w_yneg ? (HALF - w_v) : (w_v - HALF);

    logic [S-1:0] r_a1, r_b1;
    logic         r_xneg1, r_yneg1;

    // Stage 2 registers: split partial products of both squares.
    logic [2*L-1:0] r_all2, r_bll2;
    logic [S-1:0]   r_alh2, r_blh2;
    logic [2*H-1:0] r_ahh2, r_bhh2;
    logic [S-1:0]   r_a2, r_b2;
    logic           r_neg2;

    // Stage 3 registers: sum of squares.
    logic [SQ-1:0] r_sumsq3;
    logic [S-1:0]  r_a3, r_b3;
    logic          r_neg3;

    // Stage 3 logic: assemble the squares from the partial products.
    logic [SQ-1:0] w_asq, w_bsq;

    assign w_asq = (SQ'(r_ahh2) << (2 * L)) + (SQ'(r_alh2) << (L + 1)) + SQ'(r_all2);
    assign w_bsq = (SQ'(r_bhh2) << (2 * L)) + (SQ'(r_blh2) << (L + 1)) + SQ'(r_bll2);

    // Stage 4 logic: rejection and ratio overflow tests.
    logic w_reject, w_ovf;

    assign w_reject = (r_b3 == '0) || (r_sumsq3 > RADIUS);
    assign w_ovf    = RW'(r_a3) >= (RW'(r_b3) << (QUO_BITS - FRACTION_BITS));

    // Valid bits; a rejected pair leaves a bubble.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_ld1) r_v1 <= i_valid;
            if (w_ld2) r_v2 <= r_v1;
            if (w_ld3) r_v3 <= r_v2;
            if (w_ld4) r_v4 <= r_v3 && !w_reject;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_a1    <= w_a;
            r_b1    <= w_b;
            r_xneg1 <= w_xneg;
            r_yneg1 <= w_yneg;
        end
        if (w_ld2) begin
            r_all2 <= r_a1[L-1:0] * r_a1[L-1:0];
            r_alh2 <= S'(r_a1[L-1:0] * r_a1[S-1:L]);
            r_ahh2 <= r_a1[S-1:L] * r_a1[S-1:L];
            r_bll2 <= r_b1[L-1:0] * r_b1[L-1:0];
            r_blh2 <= S'(r_b1[L-1:0] * r_b1[S-1:L]);
            r_bhh2 <= r_b1[S-1:L] * r_b1[S-1:L];
            r_a2   <= r_a1;
            r_b2   <= r_b1;
            r_neg2 <= (r_a1 != '0) && (r_xneg1 != r_yneg1);
        end
        if (w_ld3) begin
            r_sumsq3 <= w_asq + w_bsq;
            r_a3     <= r_a2;
            r_b3     <= r_b2;
            r_neg3   <= r_neg2;
        end
        if (w_ld4) begin
            o_rem       <= RW'(r_a3) << FRACTION_BITS;
            o_b         <= r_b3;
            o_flags.neg <= r_neg3;
            o_flags.ovf <= w_ovf;
        end
    end

endmodule

FILE: rtl/cvg_div_stage.sv
// One restoring division stage that resolves a single quotient bit.
`timescale 1ns / 1ps

module cvg_div_stage
    import cvg_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int BIT         = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SAMPLE_BITS+31:0]    i_rem,
    input  logic [SAMPLE_BITS-1:0]     i_b,
    input  logic [QUO_BITS-1:0]        i_q,
    input  t_div_flags                 i_flags,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [SAMPLE_BITS+31:0]    o_rem,
    output logic [SAMPLE_BITS-1:0]     o_b,
    output logic [QUO_BITS-1:0]        o_q,
    output t_div_flags                 o_flags
);

    localparam int RW = SAMPLE_BITS + 32;

    logic                r_v;
    logic                w_ld;
    logic [RW-1:0]       w_trial;
    logic                w_fits;
    logic [QUO_BITS-1:0] w_q;

    assign w_ld    = !r_v || i_ready;
    assign o_ready = w_ld;
    assign o_valid = r_v;

    // Trial subtract of the divisor at this bit weight.
    assign w_trial = RW'(i_b) << BIT;
    assign w_fits  = i_rem >= w_trial;

    // Partial quotient with this stage's bit filled in.
    always_comb begin
        w_q      = i_q;
        w_q[BIT] = w_fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_ld) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            o_rem      <= w_fits ? (i_rem - w_trial) : i_rem;
            o_b        <= i_b;
            o_q        <= w_q;
            o_flags    <= i_flags;
        end
    end

endmodule

FILE: rtl/cvg_scale.sv
// Back end: ratio clipping, scale multiply, location add and saturation.
`timescale 1ns / 1ps

module cvg_scale
    import cvg_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [QUO_BITS-1:0]   i_q,
    input  t_div_flags            i_flags,
    input  logic [31:0]           i_scale,
    input  logic signed [31:0]    i_location,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_beat             o_beat
);

    localparam int PW = 64 - FRACTION_BITS;
    localparam int VW = PW + 2;
    localparam logic [QUO_BITS-1:0] NEG_LIMIT = {1'b1, {(QUO_BITS - 1){1'b0}}};
    localparam logic [QUO_BITS-1:0] POS_LIMIT = {1'b0, {(QUO_BITS - 1){1'b1}}};

    logic r_v1, r_v2, r_v3;
    logic w_ld1, w_ld2, w_ld3;

    assign w_ld3   = !r_v3 || i_ready;
    assign w_ld2   = !r_v2 || w_ld3;
    assign w_ld1   = !r_v1 || w_ld2;
    assign o_ready = w_ld1;
    assign o_valid = r_v3;

    // Stage 1 logic: clip the ratio magnitude to the signed 32-bit range.
    logic [QUO_BITS-1:0] w_qc;
    logic                w_qsat;

    always_comb begin
        w_qc   = i_q;
        w_qsat = 1'b0;
        if (i_flags.neg) begin
            if (i_flags.ovf || (i_q > NEG_LIMIT)) begin
                w_qc   = NEG_LIMIT;
                w_qsat = 1'b1;
            end
        end else begin
            if (i_flags.ovf || (i_q > POS_LIMIT)) begin
                w_qc   = POS_LIMIT;
                w_qsat = 1'b1;
            end
        end
    end

    logic [QUO_BITS-1:0] r_qc1;
    logic                r_neg1, r_sat1;
    logic [63:0]         r_prod2;
    logic                r_neg2, r_sat2;

    // Stage 3 logic: signed magnitude plus location, then saturate.
    logic [PW-1:0]        w_p;
    logic signed [VW-1:0] w_mag, w_sum;
    logic                 w_hi, w_lo;

    assign w_p   = r_prod2[63:FRACTION_BITS];
    assign w_mag = $signed({2'b00, w_p});
    assign w_sum = (r_neg2 ? -w_mag : w_mag) + VW'(i_location);
    assign w_hi  = w_sum > $signed({{(VW - 32){1'b0}}, 32'h7FFF_FFFF});
    assign w_lo  = w_sum < $signed({{(VW - 32){1'b1}}, 32'h8000_0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ld1) r_v1 <= i_valid;
            if (w_ld2) r_v2 <= r_v1;
            if (w_ld3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_qc1  <= w_qc;
            r_neg1 <= i_flags.neg;
            r_sat1 <= w_qsat;
        end
        if (w_ld2) begin
            r_prod2 <= 64'(r_qc1) * 64'(i_scale);
            r_neg2  <= r_neg1;
            r_sat2  <= r_sat1;
        end
        if (w_ld3) begin
            if (w_hi) begin
                o_beat.variate <= 32'sh7FFF_FFFF;
            end else if (w_lo) begin
                o_beat.variate <= 32'sh8000_0000;
            end else begin
                o_beat.variate <= w_sum[31:0];
            end
            o_beat.saturated <= r_sat2 || w_hi || w_lo;
        end
    end

endmodule

FILE: rtl/cauchy_variate_generator_core.sv
// Top level of the Cauchy variate generator: register port and pipeline chain.
//
// Usage: each input beat carries two uniform fractions. The pair is mapped to
// x = 2u-1 and y = 2v-1; pairs with y zero or outside the unit disk are
// dropped and give no output beat. Accepted pairs yield location plus scale
// times x/y as a saturated signed fixed-point variate with a clip flag.
// Both streams use valid/ready. From input beat to output beat the pipeline
// has 4 front stages, one divider stage per quotient bit (32), and 3
// back-end stages. Throughput is one beat per cycle while no stage stalls;
// the divider is fully pipelined, so the divide does not limit the rate.
// When the receiver stalls, each stage holds its beat and empty stages keep
// filling, so input is still taken until the pipeline is full.
// Reset clears all stage valid bits and sets location to 0 and scale to 1.0.
// location sits at byte address 0 and scale at 4 on the APB port. Users must
// write both only while the pipeline is empty; the block does not enforce it.
`timescale 1ns / 1ps

module cauchy_variate_generator_core
    import cvg_pkg::*;
#(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_beat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW = SAMPLE_BITS + 32;
    localparam logic REG_LOCATION = 1'b0;
    localparam logic REG_SCALE    = 1'b1;

    // Configuration registers.
    logic signed [31:0] r_location;
    logic [31:0]        r_scale;
    logic               w_index;

    assign pready  = 1'b1;
    assign w_index = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_location <= 32'sd0;
            r_scale    <= 32'd65536;
        end else if (psel && penable && pwrite && pready) begin
            case (w_index)
                REG_LOCATION: r_location <= pwdata;
                REG_SCALE:    r_scale    <= pwdata;
                default:      r_location <= r_location;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (w_index)
            REG_LOCATION: prdata = r_location;
            REG_SCALE:    prdata = r_scale;
            default:      prdata = '0;
        endcase
    end

    // Links along the divider chain; index 0 is the front end output.
    logic                   w_v   [0:QUO_BITS];
    logic                   w_rdy [0:QUO_BITS];
    logic [RW-1:0]          w_rem [0:QUO_BITS];
    logic [SAMPLE_BITS-1:0] w_b   [0:QUO_BITS];
    logic [QUO_BITS-1:0]    w_q   [0:QUO_BITS];
    t_div_flags             w_fl  [0:QUO_BITS];

    assign w_q[0] = '0;

    cvg_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_ready(o_in_ready),
        .i_beat (i_in_beat),
        .o_valid(w_v[0]),
        .i_ready(w_rdy[0]),
        .o_rem  (w_rem[0]),
        .o_b    (w_b[0]),
        .o_flags(w_fl[0])
    );

    // One stage per quotient bit, most significant first.
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
        cvg_div_stage #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .BIT        (QUO_BITS - 1 - k)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_v[k]),
            .o_ready(w_rdy[k]),
            .i_rem  (w_rem[k]),
            .i_b    (w_b[k]),
            .i_q    (w_q[k]),
            .i_flags(w_fl[k]),
            .o_valid(w_v[k+1]),
            .i_ready(w_rdy[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_b    (w_b[k+1]),
            .o_q    (w_q[k+1]),
            .o_flags(w_fl[k+1])
        );
    end

    cvg_scale #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_v[QUO_BITS]),
        .o_ready   (w_rdy[QUO_BITS]),
        .i_q       (w_q[QUO_BITS]),
        .i_flags   (w_fl[QUO_BITS]),
        .i_scale   (r_scale),
        .i_location(r_location),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_beat    (o_out_beat)
    );

endmodule

FILE: tb/sv/cauchy_variate_generator_core_tb.sv
// Self-checking testbench for the Cauchy variate generator core.
`timescale 1ns / 1ps

module cauchy_variate_generator_core_tb;
    import cvg_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int PIPE_LATENCY  = 39;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEMS_PER_MODE = 28;
    localparam int NUM_PROBES    = 22;
    localparam int NUM_SETTINGS  = 7;

    // Register indexes on the configuration port.
    localparam int REG_LOCATION = 0;
    localparam int REG_SCALE    = 1;

    // Idle modes: none, sender only, receiver only, both.
    localparam int SEND_IDLE_PCT [4] = '{0, 46, 0, 34};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 46, 34};

    // One row of the directed table; typed rows carry a hand-worked result.
    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        bit          typed;
        bit          keep;
        logic [31:0] variate;
        bit          sat;
    } t_probe;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_beat    i_in_beat = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_beat   o_out_beat;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copies of the registers used by the predictor.
    logic [31:0] location_reg = 32'h0000_0000;
    logic [31:0] scale_reg    = 32'h0001_0000;

    t_out_beat   variate_expect_q[$];
    t_probe      probe_tab[NUM_PROBES];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_token = 0;
    int          hold_taken = 0;
    int          hold_left = 0;

    cauchy_variate_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver ready: a requested long hold first, else random stalls.
    always @(posedge i_clk) begin
        if (hold_token != hold_taken) begin
            hold_taken = hold_token;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every output beat with the oldest pending variate.
    always @(posedge i_clk) begin : out_check
        t_out_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (variate_expect_q.size() == 0) begin
                $error("unexpected output beat: variate %h, saturated %b",
                       o_out_beat.variate, o_out_beat.saturated);
                fail_count++;
            end else begin
                want = variate_expect_q.pop_front();
                if (o_out_beat.variate !== want.variate) begin
                    $error("variate mismatch: expected %h, got %h",
                           want.variate, o_out_beat.variate);
                    fail_count++;
                end
                if (o_out_beat.saturated !== want.saturated) begin
                    $error("saturated mismatch: expected %b, got %b",
                           want.saturated, o_out_beat.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Cauchy variate of one uniform pair; returns 0 when the pair is rejected.
    function automatic bit predict_variate(input logic [31:0] u, input logic [31:0] v,
                                           input logic [31:0] loc, input logic [31:0] scl,
                                           output t_out_beat res);
        logic [63:0] half, a, b, radius_sq, ip, q, p;
        bit          xneg, yneg, neg, sat;
        longint      val;
        half = 64'h8000_0000;
        res  = '0;
        xneg = (u < half);
        yneg = (v < half);
        a = xneg ? half - u : u - half;
        b = yneg ? half - v : v - half;
        if (b == 0) return 1'b0;
        // Reject outside the unit disk.
        radius_sq = a * a + b * b;
        if (radius_sq > 64'h4000_0000_0000_0000) return 1'b0;
        // Truncated ratio magnitude; a huge integer part is marked as overflow.
        ip = a / b;
        if (ip >= (64'd1 << (32 - FRAC_BITS)))
            q = 64'h1_0000_0000;
        else
            q = (a << FRAC_BITS) / b;
        neg = (a != 0) && (xneg != yneg);
        sat = 1'b0;
        if (neg && q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            sat = 1'b1;
        end else if (!neg && q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        // Scale, apply the sign, then add location and clip.
        p = (q * {32'h0, scl}) >> FRAC_BITS;
        val = neg ? -longint'(p) : longint'(p);
        val = val + longint'($signed(loc));
        if (val > longint'(32'h7FFF_FFFF)) begin
            val = longint'(32'h7FFF_FFFF);
            sat = 1'b1;
        end
        if (val < -longint'(64'h8000_0000)) begin
            val = -longint'(64'h8000_0000);
            sat = 1'b1;
        end
        res.variate   = val[31:0];
        res.saturated = sat;
        return 1'b1;
    endfunction

    // Random pair, biased toward small denominators, small numerators and the field extremes.
    function automatic t_in_beat random_pair();
        t_in_beat    beat;
        logic [31:0] corner[5];
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0001};
        beat.first_uniform  = $urandom;
        beat.second_uniform = $urandom;
        case ($urandom_range(9))
            6, 7: begin
                beat.second_uniform = 32'h7FFF_8000 + $urandom_range(16'hFFFF);
            end
            8: begin
                beat.first_uniform = 32'h7FFF_8000 + $urandom_range(16'hFFFF);
            end
            9: begin
                beat.first_uniform  = corner[$urandom_range(4)];
                beat.second_uniform = corner[$urandom_range(4)];
            end
            default: ;
        endcase
        return beat;
    endfunction

    // Offer one input beat, record its expected variate, then idle at random.
    task automatic send_pair(input t_in_beat beat, input bit use_typed,
                             input bit typed_keep, input t_out_beat typed_res);
        t_out_beat res;
        bit        keep;
        int        gap;
        if (use_typed) begin
            keep = typed_keep;
            res  = typed_res;
        end else begin
            keep = predict_variate(beat.first_uniform, beat.second_uniform,
                                   location_reg, scale_reg, res);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (keep) variate_expect_q.push_back(res);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending, wait for every pending variate, then let rejected beats flush.
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (variate_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    // Read a register and compare it with the value it should hold.
    task automatic check_register(input int idx, input logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(idx << 2);
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== want) begin
            $error("register %0d readback mismatch: expected %h, got %h", idx, want, prdata);
            fail_count++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register, mirror it for the predictor, and read it back.
    task automatic set_register(input int idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx << 2);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LOCATION) location_reg = value;
        else if (idx == REG_SCALE) scale_reg = value;
        check_register(idx, value);
    endtask

    // Main sequence: reset, then each register setting with directed and random beats.
    initial begin : stimulus
        logic [31:0] set_loc[NUM_SETTINGS];
        logic [31:0] set_scale[NUM_SETTINGS];
        t_out_beat   typed_res;
        int          count;
        set_loc   = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h0000_0000, 32'h0000_0000, 32'h0003_0000};
        set_scale = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                      32'h0000_0000, 32'h0000_0000, 32'h0000_8000};
        set_loc[5]   = $urandom;
        set_scale[5] = $urandom_range(32'hFFFF_FFFF, 1);

        // u, v, typed, kept, variate, saturated.
        probe_tab = '{
            // Denominator zero, at the center and at the x extreme.
            '{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0},
            '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0},
            // Corners of the square lie outside the disk.
            '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
            '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
            // Just outside and exactly on the disk edge.
            '{32'h8000_0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0},
            '{32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 1'b0},
            // Zero numerator.
            '{32'h8000_0000, 32'hC000_0000, 1'b1, 1'b1, 32'h0, 1'b0},
            // Ratios of plus and minus one in all four quadrants.
            '{32'hC000_0000, 32'hC000_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
            '{32'h4000_0000, 32'hC000_0000, 1'b1, 1'b1, 32'hFFFF_0000, 1'b0},
            '{32'hC000_0000, 32'h4000_0000, 1'b1, 1'b1, 32'hFFFF_0000, 1'b0},
            '{32'h4000_0000, 32'h4000_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
            '{32'h7FFF_FFFF, 32'h8000_0001, 1'b1, 1'b1, 32'hFFFF_0000, 1'b0},
            // Ratio overflow in both directions.
            '{32'hC000_0000, 32'h8000_0001, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
            '{32'h4000_0000, 32'h8000_0001, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
            '{32'hC000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
            // Ratio of exactly 2^15: clips when positive, fits when negative.
            '{32'hA000_0000, 32'h8000_4000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
            '{32'h6000_0000, 32'h8000_4000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
            // Ordinary pairs.
            '{32'h1234_5678, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0, 1'b0},
            '{32'h9E37_79B9, 32'h7F4A_7C15, 1'b0, 1'b0, 32'h0, 1'b0},
            '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0, 1'b0},
            '{32'h8000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_register(REG_LOCATION, 32'h0000_0000);
        check_register(REG_SCALE, 32'h0001_0000);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            // The first setting runs on the reset values.
            if (s > 0) begin
                settle_pipeline();
                set_register(REG_LOCATION, set_loc[s]);
                set_register(REG_SCALE, set_scale[s]);
            end

            // Directed table; hand-worked results hold only for the reset values.
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            for (int k = 0; k < NUM_PROBES; k++) begin
                typed_res.variate   = probe_tab[k].variate;
                typed_res.saturated = probe_tab[k].sat;
                send_pair({probe_tab[k].u, probe_tab[k].v}, probe_tab[k].typed && s == 0,
                          probe_tab[k].keep, typed_res);
            end

            // Random beats under each idle mode.
            for (int m = 0; m < 4; m++) begin
                send_idle_pct  = SEND_IDLE_PCT[m];
                recv_stall_pct = RECV_STALL_PCT[m];
                count = ITEMS_PER_MODE;
                // Hold the receiver off long enough for the pipeline to back up.
                if (s == 0 && m == 0) begin
                    hold_token = hold_token + 1;
                    count = count + 100;
                end
                for (int n = 0; n < count; n++)
                    send_pair(random_pair(), 1'b0, 1'b0, typed_res);
            end
        end

        settle_pipeline();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
